// File: rtl/lsharp_pkg.sv
// lsharp_pkg: shared constants, register codes and types of the 3x3 sharpening filter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package lsharp_pkg;

    // line store geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);

    // field and register widths
    localparam int PIX_W      = 8;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 12;
    localparam int ALPHA_W    = 12;
    localparam int ROW_W      = 12;
    localparam int MAX_ROW    = 4095;
    localparam int MIN_SIZE   = 3;

    // compare width for column arithmetic (holds the width itself and col + 2)
    localparam int CMP_W = ((COL_W + 2) > (CFG_WIDTH_W + 1)) ? (COL_W + 2) : (CFG_WIDTH_W + 1);
    // compare width for row arithmetic
    localparam int ROWC_W = ROW_W + 1;

    // configuration bus
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ALPHA  = 2'd2;

    // register reset values
    localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH  = CFG_WIDTH_W'(640);
    localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT = CFG_HEIGHT_W'(480);
    localparam logic [ALPHA_W-1:0]      RST_ALPHA  = ALPHA_W'(205);

    // per-item decisions made at input time, carried to the output stage
    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } t_pos_info;

endpackage

// File: rtl/lsharp_line_buf.sv
// lsharp_line_buf: two row stores holding the previous two rows of the frame
// depends on lsharp_pkg
`timescale 1ns / 1ps

module lsharp_line_buf (
    input  logic                        i_clk,
    input  logic                        i_acc,
    input  logic [lsharp_pkg::COL_W-1:0] i_addr,
    input  logic [lsharp_pkg::PIX_W-1:0] i_pix,
    input  logic                        i_adv,
    output logic [lsharp_pkg::PIX_W-1:0] o_up,
    output logic [lsharp_pkg::PIX_W-1:0] o_lo
);
    import lsharp_pkg::*;

    logic [PIX_W-1:0] r_upper [MAX_WIDTH];
    logic [PIX_W-1:0] r_lower [MAX_WIDTH];
    logic [COL_W-1:0] r_addr;
    logic [PIX_W-1:0] r_up;
    logic [PIX_W-1:0] r_lo;

    // lower store: read old entry and write the new pixel on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_up           <= r_upper[i_addr];
            r_lo           <= r_lower[i_addr];
            r_lower[i_addr] <= i_pix;
            r_addr         <= i_addr;
        end
    end

    // upper store: old lower entry moves up when the item leaves the input stage
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_upper[r_addr] <= r_lo;
        end
    end

    assign o_up = r_up;
    assign o_lo = r_lo;

endmodule

// File: rtl/lsharp_pos.sv
// lsharp_pos: input and output position counters, emit / border / end-of-frame decisions
// depends on lsharp_pkg
`timescale 1ns / 1ps

module lsharp_pos (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_acc,
    input  logic [lsharp_pkg::CFG_WIDTH_W-1:0]  i_cfg_width,
    input  logic [lsharp_pkg::CFG_HEIGHT_W-1:0] i_cfg_height,
    output logic [lsharp_pkg::COL_W-1:0]        o_addr,
    output lsharp_pkg::t_pos_info               o_info
);
    import lsharp_pkg::*;

    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [ROW_W-1:0]  r_in_row,  n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;

    logic [CMP_W-1:0]  eff_w;
    logic [ROWC_W-1:0] eff_h;
    logic [COL_W-1:0]  col;
    logic [CMP_W-1:0]  col_inc;
    logic [CMP_W-1:0]  ocol_inc;
    logic [ROWC_W-1:0] orow_x;
    logic              emit;
    logic              interior;
    logic              last;

    // clamp frame sizes (width to MIN_SIZE..MAX_WIDTH, height to at least MIN_SIZE)
    always_comb begin
        eff_w = CMP_W'(i_cfg_width);
        if (eff_w < CMP_W'(MIN_SIZE)) begin
            eff_w = CMP_W'(MIN_SIZE);
        end else if (eff_w > CMP_W'(MAX_WIDTH)) begin
            eff_w = CMP_W'(MAX_WIDTH);
        end
        eff_h = ROWC_W'(i_cfg_height);
        if (eff_h < ROWC_W'(MIN_SIZE)) begin
            eff_h = ROWC_W'(MIN_SIZE);
        end
    end

    // position decisions for the item being accepted
    always_comb begin
        col      = (CMP_W'(r_in_col) >= eff_w) ? '0 : r_in_col;
        col_inc  = CMP_W'(col) + CMP_W'(1);
        ocol_inc = CMP_W'(r_out_col) + CMP_W'(1);
        orow_x   = ROWC_W'(r_out_row);
        emit     = (r_in_row > ROW_W'(1)) || ((r_in_row == ROW_W'(1)) && (col != '0));
        interior = (r_out_row != '0) && ((orow_x + ROWC_W'(2)) <= eff_h) &&
                   (r_out_col != '0) && ((ocol_inc + CMP_W'(1)) <= eff_w);
        last     = ((orow_x + ROWC_W'(1)) >= eff_h) && (ocol_inc >= eff_w);
    end

    // next counter values
    always_comb begin
        n_in_col  = col_inc[COL_W-1:0];
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (col_inc >= eff_w) begin
            n_in_col = '0;
            if (r_in_row != ROW_W'(MAX_ROW)) begin
                n_in_row = r_in_row + ROW_W'(1);
            end
        end
        if (emit) begin
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (ocol_inc >= eff_w) begin
                n_out_col = '0;
                n_out_row = r_out_row + ROW_W'(1);
            end else begin
                n_out_col = ocol_inc[COL_W-1:0];
            end
        end
    end

    // counters step once per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_acc) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    assign o_addr          = col;
    assign o_info.emit     = emit;
    assign o_info.interior = interior;
    assign o_info.last     = last;

endmodule

// File: rtl/lsharp_core.sv
// lsharp_core: window taps, Laplacian sharpening arithmetic and the result register
// depends on lsharp_pkg
`timescale 1ns / 1ps

module lsharp_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  lsharp_pkg::t_pos_info         i_info,
    input  logic [lsharp_pkg::PIX_W-1:0]   i_pix,
    input  logic [lsharp_pkg::PIX_W-1:0]   i_up,
    input  logic [lsharp_pkg::PIX_W-1:0]   i_lo,
    input  logic [lsharp_pkg::ALPHA_W-1:0] i_alpha,
    output logic [lsharp_pkg::PIX_W-1:0]   o_pixel,
    output logic                          o_last
);
    import lsharp_pkg::*;

    // only the taps that feed the cross-shaped kernel are kept:
    // top-right, middle-center, middle-right, bottom-right of the window
    logic [PIX_W-1:0] r_t2, r_t4, r_t5, r_t8;
    logic [PIX_W-1:0] r_pixel;
    logic             r_last;

    logic [PIX_W+1:0]  nb_sum;
    logic signed [10:0] lap;
    logic signed [23:0] prod;
    logic signed [24:0] v;
    logic [PIX_W-1:0]  sharp;
    logic [PIX_W-1:0]  center;

    // kernel on the shifted window: up = t2, down = t8, left = t4, right = new lower tap
    always_comb begin
        center = r_t5;
        nb_sum = 10'(r_t2) + 10'(r_t8) + 10'(r_t4) + 10'(i_lo);
        lap    = signed'({1'b0, nb_sum}) - signed'({1'b0, center, 2'b00});
        prod   = signed'(24'(i_alpha)) * signed'({{13{lap[10]}}, lap});
        v      = signed'({9'd0, center, 8'd0}) - signed'({prod[23], prod});
        if (v[24]) begin
            sharp = '0;
        end else if (v[23:16] != '0) begin
            sharp = '1;
        end else begin
            sharp = v[15:8];
        end
    end

    // window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2 <= '0;
            r_t4 <= '0;
            r_t5 <= '0;
            r_t8 <= '0;
        end else if (i_adv) begin
            r_t2 <= i_up;
            r_t4 <= r_t5;
            r_t5 <= i_lo;
            r_t8 <= i_pix;
        end
    end

    // result register, border pixels pass through
    always_ff @(posedge i_clk) begin
        if (i_adv && i_info.emit) begin
            r_pixel <= i_info.interior ? sharp : center;
            r_last  <= i_info.last;
        end
    end

    assign o_pixel = r_pixel;
    assign o_last  = r_last;

endmodule

// File: rtl/laplacian_sharpen_3x3.sv
// Laplacian sharpening 3x3 filter: a result is registered when the item that completes it
// leaves the input stage register (pixel results lag their input by one row plus one item).
// Throughput one transaction per cycle unless the output stalls, set by the input
// register -> result register pass. Reset is synchronous active low: counters, window taps,
// valids and registers return to defaults; the row stores are not cleared and need no
// clearing pass. Depends on lsharp_pkg, lsharp_pos, lsharp_line_buf, lsharp_core.
`timescale 1ns / 1ps

module laplacian_sharpen_3x3 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] pixel
    input  logic                          s_axis_tuser,   // [0] kind (1 = flush tick)
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] out_pixel
    output logic                          m_axis_tlast,   // last_of_frame
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsharp_pkg::APB_AW-1:0]  paddr,
    input  logic [lsharp_pkg::APB_DW-1:0]  pwdata,
    output logic [lsharp_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import lsharp_pkg::*;

    logic [CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [CFG_HEIGHT_W-1:0] r_cfg_height;
    logic [ALPHA_W-1:0]      r_cfg_alpha;

    logic             r_s1_v;
    logic [PIX_W-1:0] r_s1_pix;
    t_pos_info        r_s1_info;
    logic             r_o_v;

    logic             acc;
    logic             adv;
    logic             wr;
    logic [1:0]       reg_idx;
    logic [COL_W-1:0] addr;
    t_pos_info        info;
    logic [PIX_W-1:0] up_rd;
    logic [PIX_W-1:0] lo_rd;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_alpha  <= RST_ALPHA;
        end else if (wr) begin
            case (reg_idx)
                REG_WIDTH:  r_cfg_width  <= pwdata[CFG_WIDTH_W-1:0];
                REG_HEIGHT: r_cfg_height <= pwdata[CFG_HEIGHT_W-1:0];
                REG_ALPHA:  r_cfg_alpha  <= pwdata[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:  prdata = APB_DW'(r_cfg_width);
            REG_HEIGHT: prdata = APB_DW'(r_cfg_height);
            REG_ALPHA:  prdata = APB_DW'(r_cfg_alpha);
            default:    prdata = '0;
        endcase
    end

    // handshake: the input stage moves on unless its result would overwrite a stalled one
    assign adv           = r_s1_v && (!r_s1_info.emit || !r_o_v || m_axis_tready);
    assign s_axis_tready = !r_s1_v || adv;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_o_v;

    // input stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (acc) begin
            r_s1_v <= 1'b1;
        end else if (adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix  <= s_axis_tuser ? '0 : s_axis_tdata;
            r_s1_info <= info;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (adv && r_s1_info.emit) begin
            r_o_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_v <= 1'b0;
        end
    end

    lsharp_pos u_pos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_cfg_width  (r_cfg_width),
        .i_cfg_height (r_cfg_height),
        .o_addr       (addr),
        .o_info       (info)
    );

    lsharp_line_buf u_line_buf (
        .i_clk  (i_clk),
        .i_acc  (acc),
        .i_addr (addr),
        .i_pix  (s_axis_tuser ? {PIX_W{1'b0}} : s_axis_tdata),
        .i_adv  (adv),
        .o_up   (up_rd),
        .o_lo   (lo_rd)
    );

    lsharp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_info  (r_s1_info),
        .i_pix   (r_s1_pix),
        .i_up    (up_rd),
        .i_lo    (lo_rd),
        .i_alpha (r_cfg_alpha),
        .o_pixel (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // input is refused only while the input stage holds an item
    a_ready_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_v)
        else $error("input refused with empty input stage");

    // a held item that cannot move stays in the input stage
    a_stall_keeps_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !adv) |=> r_s1_v)
        else $error("stalled item lost from input stage");

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_info.emit) |-> (!r_o_v || m_axis_tready))
        else $error("result overwritten while stalled");

    // an emitting item always shows up at the output
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_info.emit) |=> m_axis_tvalid)
        else $error("emitted result missing at output");
`endif

endmodule

// File: dv/tb_top.sv
// tb_top: self-checking bench for laplacian_sharpen_3x3; streams whole frames with random
// gaps and stalls and checks every output pixel against a line-store/window predictor
// depends on lsharp_pkg and the laplacian_sharpen_3x3 rtl
`timescale 1ns / 1ps

module tb_top;
    import lsharp_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int IDLE_PCT    = 17;
    localparam int DRAIN_GAP   = 8;
    localparam int RAND_ITEMS  = 570;

    typedef struct packed {
        logic       flush;
        logic [7:0] pix;
    } t_pixel_item;

    typedef struct packed {
        logic [7:0] pix;
        logic       last;
    } t_sharp_px;

    // clock, reset and dut ports
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;   // [7:0] pixel
    logic              s_axis_tuser  = 1'b0; // [0] kind (1 = flush tick)
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;         // [7:0] out_pixel
    logic              m_axis_tlast;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    laplacian_sharpen_3x3 dut (.*);

    // stimulus and bookkeeping
    t_pixel_item pending_items[$];
    t_sharp_px   sharp_expected[$];
    logic        quiet       = 1'b0;
    logic        rx_hold_req = 1'b0;
    logic        rx_hold_done = 1'b0;
    int          rx_hold_left = 0;
    int          err_count = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          frames_done = 0;
    int          settings_used = 0;
    int          stall_cycles = 0;
    int unsigned eff_w = 3;
    int unsigned eff_h = 3;
    int unsigned max_w_seen = 0;
    int unsigned max_h_seen = 0;

    // predictor state
    logic [CFG_WIDTH_W-1:0]  cfg_width  = RST_WIDTH;
    logic [CFG_HEIGHT_W-1:0] cfg_height = RST_HEIGHT;
    logic [ALPHA_W-1:0]      cfg_alpha  = RST_ALPHA;
    logic [7:0]  line_up [MAX_WIDTH];
    logic [7:0]  line_lo [MAX_WIDTH];
    logic [7:0]  taps [9];   // [row*3 + col], col 2 newest
    int unsigned col_in, row_in, col_out, row_out;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= 20) $display("mismatch: %s", msg);
    endtask

    // centre minus alpha times the 4-neighbour laplacian, floored and saturated
    function automatic logic [7:0] sharpen_px();
        longint c, up, dn, lf, rt, a, lap, v;
        c   = taps[4];
        up  = taps[1];
        dn  = taps[7];
        lf  = taps[3];
        rt  = taps[5];
        a   = cfg_alpha;
        lap = up + dn + lf + rt - 4 * c;
        v   = 256 * c - a * lap;
        if (v < 0) return 8'd0;
        v = v >>> 8;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // advance line stores, window and counters by one accepted transaction
    task automatic sharpen_step(input logic flush, input logic [7:0] pix_in);
        int unsigned w, h;
        logic [7:0]  p, up_old, lo_old, res;
        bit          emit, interior, last;
        t_sharp_px   exp_px;
        w = clamp_size(cfg_width, MAX_WIDTH);
        h = clamp_size(cfg_height, MAX_ROW);
        p = flush ? 8'd0 : pix_in;
        up_old = '0;
        lo_old = '0;
        if (col_in >= w) col_in = 0;
        if (col_in < MAX_WIDTH) begin
            up_old = line_up[col_in];
            lo_old = line_lo[col_in];
            line_up[col_in] = lo_old;
            line_lo[col_in] = p;
        end
        for (int r = 0; r < 3; r++) begin
            taps[r * 3]     = taps[r * 3 + 1];
            taps[r * 3 + 1] = taps[r * 3 + 2];
        end
        taps[2] = up_old;
        taps[5] = lo_old;
        taps[8] = p;
        emit = (row_in > 1) || (row_in == 1 && col_in >= 1);
        col_in++;
        if (col_in >= w) begin
            col_in = 0;
            if (row_in < MAX_ROW) row_in++;
        end
        if (emit) begin
            interior = row_out >= 1 && row_out + 2 <= h && col_out >= 1 && col_out + 2 <= w;
            last     = row_out + 1 >= h && col_out + 1 >= w;
            res      = interior ? sharpen_px() : taps[4];
            exp_px.pix  = res;
            exp_px.last = last;
            sharp_expected = {sharp_expected, exp_px};
            if (last) begin
                col_in  = 0;
                row_in  = 0;
                col_out = 0;
                row_out = 0;
            end else begin
                col_out++;
                if (col_out >= w) begin
                    col_out = 0;
                    row_out++;
                end
            end
        end
    endtask

    // predictor: register shadow and input transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width  = RST_WIDTH;
            cfg_height = RST_HEIGHT;
            cfg_alpha  = RST_ALPHA;
            col_in  = 0;
            row_in  = 0;
            col_out = 0;
            row_out = 0;
            for (int i = 0; i < 9; i++) taps[i] = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_WIDTH:  cfg_width  = pwdata[CFG_WIDTH_W-1:0];
                    REG_HEIGHT: cfg_height = pwdata[CFG_HEIGHT_W-1:0];
                    REG_ALPHA:  cfg_alpha  = pwdata[ALPHA_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) sharpen_step(s_axis_tuser, s_axis_tdata);
        end
    end

    // driver: offers queued items, random gaps unless quiet
    always @(posedge i_clk) begin
        t_pixel_item nxt;
        bit          go;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            go = pending_items.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT);
            if (go) begin
                nxt = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.pix;
                s_axis_tuser  <= nxt.flush;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= 0;
        end else if (rx_hold_req && !rx_hold_done) begin
            rx_hold_done  <= 1'b1;
            rx_hold_left  <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left  <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // monitor: compare each output transaction with the oldest expected pixel
    always @(posedge i_clk) begin
        t_sharp_px want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (sharp_expected.size() == 0) begin
                report_mismatch($sformatf("result %0d: unexpected pixel %0d last %0b",
                                          results_seen, m_axis_tdata, m_axis_tlast));
            end else begin
                want = sharp_expected.pop_front();
                if (m_axis_tdata !== want.pix)
                    report_mismatch($sformatf("result %0d: pixel %0d, wanted %0d",
                                              results_seen, m_axis_tdata, want.pix));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("result %0d: last %0b, wanted %0b",
                                              results_seen, m_axis_tlast, want.last));
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", stall_cycles);
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_item(input logic flush, input logic [7:0] pix);
        t_pixel_item it;
        it.flush = flush;
        it.pix   = pix;
        pending_items = {pending_items, it};
        items_sent++;
    endtask

    // apb write: setup, access, then back to idle
    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_reg(input logic [1:0] idx, input logic [APB_DW-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d read 0x%0h, wanted 0x%0h", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned a);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_ALPHA, a);
        read_reg(REG_WIDTH, w);
        read_reg(REG_HEIGHT, h);
        read_reg(REG_ALPHA, a);
        eff_w = clamp_size(w, MAX_WIDTH);
        eff_h = clamp_size(h, MAX_ROW);
        if (eff_w > max_w_seen) max_w_seen = eff_w;
        if (eff_h > max_h_seen) max_h_seen = eff_h;
        settings_used++;
    endtask

    // one full frame plus its drain; some flushes land inside the frame
    task automatic queue_frame();
        int unsigned n_px;
        n_px = eff_w * eff_h;
        for (int unsigned i = 0; i < n_px; i++) begin
            if ($urandom_range(99) < 3)
                push_item(1'b1, 8'($urandom));
            else if ($urandom_range(9) == 0)
                push_item(1'b0, $urandom_range(1) ? 8'hFF : 8'h00);
            else
                push_item(1'b0, 8'($urandom));
        end
        for (int unsigned i = 0; i <= eff_w; i++) push_item(1'($urandom_range(1)), 8'($urandom));
    endtask

    // wait until every queued item went in and every expected pixel came out
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_axis_tvalid || sharp_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
        frames_done++;
    endtask

    initial begin
        int          k;
        int          rand_base;
        logic [7:0]  bright_ring [9];
        for (int i = 0; i < MAX_WIDTH; i++) begin
            line_up[i] = '0;
            line_lo[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: clamped 3x3, max gain, bright centre on black saturates high,
        // pixels during drain never reach a result
        set_config(0, 0, 4095);
        for (int i = 0; i < 9; i++) push_item(1'b0, (i == 4) ? 8'd255 : 8'd0);
        push_item(1'b0, 8'd200);
        push_item(1'b1, 8'd0);
        push_item(1'b1, 8'hFF);
        push_item(1'b0, 8'd77);
        wait_idle();

        // directed: white ring around a flush inside the frame (taken as black)
        for (int i = 0; i < 9; i++) bright_ring[i] = 8'd255;
        for (int i = 0; i < 9; i++) push_item(i == 4, bright_ring[i]);
        for (int i = 0; i < 4; i++) push_item(1'b1, 8'($urandom));
        wait_idle();

        // random frames over a sweep of sizes and gains
        rand_base = items_sent;
        k = 0;
        while (items_sent - rand_base < RAND_ITEMS || k < 10) begin
            case (k)
                0: set_config(5, 4, 0);
                1: begin
                    set_config(16, 8, 256);
                    rx_hold_req <= 1'b1;
                end
                2: set_config(1, 7, $urandom_range(4095));
                5: set_config(24, 3, $urandom_range(4095));
                8: set_config(3, 30, $urandom_range(4095));
                default: set_config($urandom_range(12, 2), $urandom_range(8, 2),
                                    $urandom_range(1) ? $urandom_range(4095)
                                                      : $urandom_range(600));
            endcase
            quiet <= (k >= 4 && k <= 7);
            queue_frame();
            wait_idle();
            k++;
        end

        repeat (DRAIN_GAP) @(posedge i_clk);
        if (sharp_expected.size() != 0)
            report_mismatch($sformatf("%0d expected pixels never came out",
                                      sharp_expected.size()));
        $display("covered %0d frames under %0d settings: %0d input transactions, %0d pixels checked",
                 frames_done, settings_used, items_sent, results_seen);
        $display("sizes up to %0d wide and %0d rows, gain 0 to 4095, mismatches %0d",
                 max_w_seen, max_h_seen, err_count);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
